[design/pltl_pkg.sv]
// Shared types and constants for the piecewise linear transfer lookup.
package pltl_pkg;
    localparam int MaxPointsDef = 16;
    localparam int IntW = 16;
    localparam int ColW = 8;
    localparam int OpaW = 16;
    localparam int CntW = 5;
    localparam logic [15:0] RangeLowRst = 16'd0;
    localparam logic [15:0] RangeHighRst = 16'd4000;
    localparam logic [4:0] PointCountRst = 5'd2;
    localparam logic ActWrite = 1'b0;
    localparam logic ActLookup = 1'b1;
    localparam logic [1:0] RegRangeLow = 2'd0;
    localparam logic [1:0] RegRangeHigh = 2'd1;
    localparam logic [1:0] RegPointCount = 2'd2;
    // Divider steps: one per quotient bit of a 32-bit numerator.
    localparam int DivSteps = 32;

    typedef enum logic [1:0] {
        t_ST_IDLE,
        t_ST_SCAN,
        t_ST_DIV,
        t_ST_DONE
    } t_state;

    // Control point as stored in one cell.
    typedef struct packed {
        logic [IntW-1:0] intensity;
        logic [ColW-1:0] red;
        logic [ColW-1:0] green;
        logic [ColW-1:0] blue;
        logic [OpaW-1:0] opacity;
    } t_point;

    // Word moving along the cell chain during a scan.
    typedef struct packed {
        logic            valid;
        t_point          prev;
    } t_scan;
endpackage

[design/pltl_in_if.sv]
// Input channel interface: one write or lookup word.
interface pltl_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  point_index;
    logic [15:0] point_intensity;
    logic [7:0]  point_red;
    logic [7:0]  point_green;
    logic [7:0]  point_blue;
    logic [15:0] point_opacity;
    logic [15:0] query_intensity;
    modport source(output valid, action, point_index, point_intensity, point_red,
        point_green, point_blue, point_opacity, query_intensity, input ready);
    modport sink(input valid, action, point_index, point_intensity, point_red,
        point_green, point_blue, point_opacity, query_intensity, output ready);
endinterface

[design/pltl_out_if.sv]
// Output channel interface: one lookup result word.
interface pltl_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [15:0] out_opacity;
    logic        segment_found;
    modport source(output valid, out_red, out_green, out_blue, out_opacity,
        segment_found, input ready);
    modport sink(input valid, out_red, out_green, out_blue, out_opacity,
        segment_found, output ready);
endinterface

[design/pltl_cell.sv]
// One control point cell: holds a point and shifts it toward the scan head.
module pltl_cell
    import pltl_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_wr,
    input  t_point i_wr_point,
    input  logic   i_shift,
    input  t_point i_next,
    output t_point o_point
);
    t_point r_point;
    // Load on write, rotate on shift
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_point <= i_wr_point;
        end else if (i_shift) begin
            r_point <= i_next;
        end
    end
    assign o_point = r_point;
endmodule

[design/pltl_div.sv]
// Restoring divider, one quotient bit per cycle, for the four channel lerps.
module pltl_div
    import pltl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [15:0] i_den,
    output logic [31:0] o_quot
);
    logic [31:0] r_quot;
    logic [16:0] r_rem;
    logic [16:0] w_trial;
    assign w_trial = {r_rem[15:0], r_quot[31]};
    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
        end else begin
            if (w_trial >= {1'b0, i_den}) begin
                r_rem  <= w_trial - {1'b0, i_den};
                r_quot <= {r_quot[30:0], 1'b1};
            end else begin
                r_rem  <= w_trial;
                r_quot <= {r_quot[30:0], 1'b0};
            end
        end
    end
    assign o_quot = r_quot;
endmodule

[design/piecewise_linear_transfer_lookup.sv]
// Top level of the piecewise linear transfer lookup.
// A write word loads one control point. A lookup rotates the
// chain of point cells past a compare head, one point per cycle, for a
// full rotation. It then forms the numerators, loads four bit-serial
// dividers (red, green, blue, opacity), runs DivSteps divide steps and
// registers the result; clamped lookups take the same path. The result
// sits in an output register and the next word is taken once it is
// handed over.
module piecewise_linear_transfer_lookup
    import pltl_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pltl_in_if.sink     in_ch,
    pltl_out_if.source  out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [15:0] r_range_low, r_range_high;
    logic [4:0]  r_point_count;
    t_state r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic [5:0] r_dcnt;
    logic [15:0] r_x;
    logic r_clamp, r_seg;
    t_point r_p0, r_p1, r_prev, r_clamp_pt;
    logic r_ovalid;
    logic [7:0] r_ored, r_ogreen, r_oblue;
    logic [15:0] r_oopa;
    logic r_ofound;

    t_point w_pt [MAX_POINTS];
    logic w_wr [MAX_POINTS];
    logic w_shift;
    t_point w_wpt;
    logic [CW-1:0] w_n;
    logic w_acc, w_write;

    // Configuration port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low   <= RangeLowRst;
            r_range_high  <= RangeHighRst;
            r_point_count <= PointCountRst;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegRangeLow:   r_range_low   <= pwdata[15:0];
                RegRangeHigh:  r_range_high  <= pwdata[15:0];
                RegPointCount: r_point_count <= pwdata[4:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[3:2])
            RegRangeLow:   prdata = {16'd0, r_range_low};
            RegRangeHigh:  prdata = {16'd0, r_range_high};
            RegPointCount: prdata = {27'd0, r_point_count};
            default:       prdata = '0;
        endcase
    end

    // Points in use, clamped to 1..MAX_POINTS
    always_comb begin
        if ({27'd0, r_point_count} > MAX_POINTS) w_n = CW'(MAX_POINTS);
        else if (r_point_count == 5'd0) w_n = CW'(1);
        else w_n = CW'(r_point_count);
    end

    assign in_ch.ready = (r_state == t_ST_IDLE) && !r_ovalid;
    assign w_acc = in_ch.valid && in_ch.ready;
    assign w_write = w_acc && (in_ch.action == ActWrite);
    assign w_wpt = '{in_ch.point_intensity, in_ch.point_red, in_ch.point_green,
                     in_ch.point_blue, in_ch.point_opacity};
    assign w_shift = (r_state == t_ST_SCAN);

    // Cell chain: cell k takes cell k+1, last takes cell 0 (full rotation)
    for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
        assign w_wr[k] = w_write && ({28'd0, in_ch.point_index} == 32'(k));
        pltl_cell u_cell (
            .i_clk(i_clk), .i_wr(w_wr[k]), .i_wr_point(w_wpt),
            .i_shift(w_shift), .i_next(w_pt[(k + 1) % MAX_POINTS]),
            .o_point(w_pt[k])
        );
    end

    // Head compare for segment (r_cnt-1, r_cnt)
    logic w_hit;
    assign w_hit = (r_cnt != '0) && (r_cnt < w_n) && !r_seg &&
                   (r_x >= r_prev.intensity) && (r_x < w_pt[0].intensity);

    // Dividers
    logic [15:0] w_den;
    logic [15:0] w_dx;
    logic [8:0]  w_dr, w_dg, w_db;
    logic [16:0] w_do;
    logic [31:0] w_qr, w_qg, w_qb, w_qo;
    logic w_dstart;
    assign w_den = r_p1.intensity - r_p0.intensity;
    assign w_dx  = r_x - r_p0.intensity;
    assign w_dr = {1'b0, r_p1.red} - {1'b0, r_p0.red};
    assign w_dg = {1'b0, r_p1.green} - {1'b0, r_p0.green};
    assign w_db = {1'b0, r_p1.blue} - {1'b0, r_p0.blue};
    assign w_do = {1'b0, r_p1.opacity} - {1'b0, r_p0.opacity};
    // Load the dividers once the numerators reflect the final segment
    assign w_dstart = (r_state == t_ST_DIV) && (r_dcnt == 6'd1);

    function automatic logic [31:0] absmul(input logic [16:0] d, input logic [15:0] x);
        logic [16:0] a;
        a = d[16] ? (17'd0 - d) : d;
        return 32'(a[15:0] * x) + (a[16] ? {x, 16'd0} : 32'd0);
    endfunction

    logic [31:0] r_nr, r_ng, r_nb, r_no;
    logic r_sr, r_sg, r_sb, r_so;
    pltl_div u_dr (.i_clk(i_clk), .i_start(w_dstart), .i_num(r_nr), .i_den(w_den), .o_quot(w_qr));
    pltl_div u_dg (.i_clk(i_clk), .i_start(w_dstart), .i_num(r_ng), .i_den(w_den), .o_quot(w_qg));
    pltl_div u_db (.i_clk(i_clk), .i_start(w_dstart), .i_num(r_nb), .i_den(w_den), .o_quot(w_qb));
    pltl_div u_do (.i_clk(i_clk), .i_start(w_dstart), .i_num(r_no), .i_den(w_den), .o_quot(w_qo));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_ST_IDLE: if (w_acc && in_ch.action == ActLookup) n_state = t_ST_SCAN;
            t_ST_SCAN: if (r_cnt == CW'(MAX_POINTS - 1)) n_state = t_ST_DIV;
            t_ST_DIV:  if (r_dcnt == 6'(DivSteps + 1)) n_state = t_ST_DONE;
            t_ST_DONE: n_state = t_ST_IDLE;
            default:   n_state = t_ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan datapath: capture clamp point and first matching segment
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_dcnt <= '0;
            r_seg <= 1'b0;
            r_clamp <= 1'b0;
        end else begin
            case (r_state)
                t_ST_IDLE: begin
                    r_cnt <= '0;
                    r_dcnt <= '0;
                    r_seg <= 1'b0;
                    r_x <= in_ch.query_intensity;
                    r_clamp <= (in_ch.query_intensity <= r_range_low) ||
                               (in_ch.query_intensity >= r_range_high);
                end
                t_ST_SCAN: begin
                    r_cnt <= r_cnt + CW'(1);
                    r_prev <= w_pt[0];
                    if (r_cnt == '0 && r_x <= r_range_low) r_clamp_pt <= w_pt[0];
                    if (r_x > r_range_low && r_cnt == w_n - CW'(1)) begin
                        r_clamp_pt <= w_pt[0];
                    end
                    if (w_hit) begin
                        r_seg <= 1'b1;
                        r_p0 <= r_prev;
                        r_p1 <= w_pt[0];
                    end
                end
                t_ST_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                end
                default: ;
            endcase
        end
    end

    // Numerators registered ahead of divide start
    always_ff @(posedge i_clk) begin
        r_nr <= absmul({{8{w_dr[8]}}, w_dr}, w_dx);
        r_ng <= absmul({{8{w_dg[8]}}, w_dg}, w_dx);
        r_nb <= absmul({{8{w_db[8]}}, w_db}, w_dx);
        r_no <= absmul(w_do, w_dx);
        r_sr <= w_dr[8];
        r_sg <= w_dg[8];
        r_sb <= w_db[8];
        r_so <= w_do[16];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == t_ST_DONE) begin
            r_ovalid <= 1'b1;
            if (r_clamp) begin
                r_ored <= r_clamp_pt.red;
                r_ogreen <= r_clamp_pt.green;
                r_oblue <= r_clamp_pt.blue;
                r_oopa <= r_clamp_pt.opacity;
                r_ofound <= 1'b1;
            end else if (r_seg) begin
                r_ored <= r_p0.red + (r_sr ? 8'(0 - w_qr[7:0]) : w_qr[7:0]);
                r_ogreen <= r_p0.green + (r_sg ? 8'(0 - w_qg[7:0]) : w_qg[7:0]);
                r_oblue <= r_p0.blue + (r_sb ? 8'(0 - w_qb[7:0]) : w_qb[7:0]);
                r_oopa <= r_p0.opacity + (r_so ? 16'(0 - w_qo[15:0]) : w_qo[15:0]);
                r_ofound <= 1'b1;
            end else begin
                r_ored <= '0;
                r_ogreen <= '0;
                r_oblue <= '0;
                r_oopa <= '0;
                r_ofound <= 1'b0;
            end
        end else if (out_ch.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.out_red = r_ored;
    assign out_ch.out_green = r_ogreen;
    assign out_ch.out_blue = r_oblue;
    assign out_ch.out_opacity = r_oopa;
    assign out_ch.segment_found = r_ofound;
endmodule
